@@ hw/rtl/ipc_pkg.sv @@
package ipc_pkg;

	// Queue depth default
	localparam int QUEUE_DEPTH_DEF = 32;

	// Configuration port geometry and register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WATER_LEVEL      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PUMP_MS_PER_ML       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_RETRY_MS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_PERIOD_MS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_AFTER_CMD_MS = 3'd4;

	// Register reset values
	localparam logic [6:0]  MIN_WATER_LEVEL_RST      = 7'd5;
	localparam logic [7:0]  PUMP_MS_PER_ML_RST       = 8'd80;
	localparam logic [15:0] AUTO_RETRY_MS_RST        = 16'd60000;
	localparam logic [15:0] PUBLISH_PERIOD_MS_RST    = 16'd10000;
	localparam logic [15:0] PUBLISH_AFTER_CMD_MS_RST = 16'd1000;

	// Item kinds
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_STEP    = 2'd1;
	localparam logic [1:0] FUNC_CMD     = 2'd2;
	localparam logic [1:0] FUNC_IGNORED = 2'd3;

	// Modes and error bits
	localparam logic RUN_MANUAL = 1'b0;
	localparam logic RUN_AUTO   = 1'b1;
	localparam int ERR_PRESSURE_BIT = 0;
	localparam int ERR_LEVEL_BIT    = 1;

	// Command clamp limits
	localparam int MAX_MOIST = 100;
	localparam int MAX_WATER = 750;

	typedef struct packed {
		logic [1:0]          func;
		logic signed [15:0]  moisture_reading;
		logic [15:0]         light_reading;
		logic signed [15:0]  water_level_reading;
		logic signed [15:0]  cmd_mode;
		logic signed [31:0]  cmd_moisture;
		logic signed [31:0]  cmd_water;
	} in_item_t;

	typedef struct packed {
		logic                pump_on;
		logic [1:0]          error_flags;
		logic                current_mode;
		logic                status_valid;
		logic signed [15:0]  status_water_level;
		logic [15:0]         status_light;
		logic signed [15:0]  status_moisture;
		logic                command_dropped;
	} out_item_t;

	// One queued command
	typedef struct packed {
		logic        mode;
		logic [6:0]  moisture;
		logic [9:0]  water;
	} cmd_entry_t;

	localparam int ENTRY_W = $bits(cmd_entry_t);

	typedef struct packed {
		logic                    valid;
		logic [CFG_IDX_W-1:0]    index;
		logic [CFG_DATA_W-1:0]   data;
	} cfg_wr_t;

	typedef struct packed {
		logic        push;
		logic        pop;
		cmd_entry_t  entry;
	} q_req_t;

	typedef struct packed {
		logic        nonempty;
		logic        full;
		cmd_entry_t  head;
	} q_stat_t;

endpackage

@@ hw/rtl/ipc_ram.sv @@
module ipc_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ipc_cmd_queue.sv @@
module ipc_cmd_queue #(
	parameter int QUEUE_DEPTH = ipc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  ipc_pkg::q_req_t   req,
	output ipc_pkg::q_stat_t  stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_nxt;
	logic [ipc_pkg::ENTRY_W-1:0] ram_rdata;
	logic fwd_q;
	ipc_pkg::cmd_entry_t fwd_data_q;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		wrap_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Read the head that the next transaction will see
	assign head_nxt = req.pop ? wrap_next(head_q) : head_q;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_nxt;
			if (req.push) begin
				tail_q <= wrap_next(tail_q);
			end
			priority if (req.push && !req.pop) begin
				count_q <= count_q + 1'b1;
			end else if (req.pop && !req.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Forward a push that lands on the entry being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= req.push && (tail_q == head_nxt);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= req.entry;
		end
	end

	ipc_ram #(
		.WIDTH(ipc_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.push),
		.waddr (tail_q),
		.wdata (req.entry),
		.re    (rd_en),
		.raddr (head_nxt),
		.rdata (ram_rdata)
	);

	assign stat.nonempty = (count_q != '0);
	assign stat.full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.head     = fwd_q ? fwd_data_q : ipc_pkg::cmd_entry_t'(ram_rdata);

endmodule

@@ hw/rtl/ipc_core.sv @@
module ipc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  ipc_pkg::cfg_wr_t   cfg,
	input  logic               go,
	input  ipc_pkg::in_item_t  item,
	input  ipc_pkg::q_stat_t   q_stat,
	output ipc_pkg::q_req_t    q_req,
	output ipc_pkg::out_item_t result
);

	// Configuration registers
	logic [6:0]  min_level_q;
	logic [7:0]  ms_per_ml_q;
	logic [15:0] retry_q;
	logic [15:0] period_q;
	logic [15:0] after_cmd_q;

	// Controller state
	logic        mode_q,   mode_d;
	logic [6:0]  sp_q,     sp_d;
	logic [9:0]  amt_q,    amt_d;
	logic [15:0] auto_q,   auto_d;
	logic [15:0] pub_q,    pub_d;
	logic [15:0] pump_q,   pump_d;
	logic [1:0]  err_q,    err_d;

	logic        status;
	logic        dropped;
	logic        pump_req;
	logic [9:0]  pump_amt;
	logic [17:0] pump_prod;
	logic [15:0] pump_time;
	logic        level_ok;
	logic        too_dry;
	logic [6:0]  cmd_moist;
	logic [9:0]  cmd_water;
	ipc_pkg::cmd_entry_t cmd_entry;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= ipc_pkg::MIN_WATER_LEVEL_RST;
			ms_per_ml_q <= ipc_pkg::PUMP_MS_PER_ML_RST;
			retry_q     <= ipc_pkg::AUTO_RETRY_MS_RST;
			period_q    <= ipc_pkg::PUBLISH_PERIOD_MS_RST;
			after_cmd_q <= ipc_pkg::PUBLISH_AFTER_CMD_MS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ipc_pkg::REG_MIN_WATER_LEVEL:      min_level_q <= cfg.data[6:0];
				ipc_pkg::REG_PUMP_MS_PER_ML:       ms_per_ml_q <= cfg.data[7:0];
				ipc_pkg::REG_AUTO_RETRY_MS:        retry_q     <= cfg.data;
				ipc_pkg::REG_PUBLISH_PERIOD_MS:    period_q    <= cfg.data;
				ipc_pkg::REG_PUBLISH_AFTER_CMD_MS: after_cmd_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Clamp an incoming command into a queue entry
	always_comb begin
		if (item.cmd_moisture[31]) begin
			cmd_moist = '0;
		end else if (item.cmd_moisture[30:0] > 31'(ipc_pkg::MAX_MOIST)) begin
			cmd_moist = 7'(ipc_pkg::MAX_MOIST);
		end else begin
			cmd_moist = item.cmd_moisture[6:0];
		end
		if (item.cmd_water[31]) begin
			cmd_water = '0;
		end else if (item.cmd_water[30:0] > 31'(ipc_pkg::MAX_WATER)) begin
			cmd_water = 10'(ipc_pkg::MAX_WATER);
		end else begin
			cmd_water = item.cmd_water[9:0];
		end
	end

	assign cmd_entry.mode     = (item.cmd_mode == 16'sd1) ? ipc_pkg::RUN_AUTO
	                                                      : ipc_pkg::RUN_MANUAL;
	assign cmd_entry.moisture = cmd_moist;
	assign cmd_entry.water    = cmd_water;

	// Pump time from the popped amount, or the held one in auto mode
	assign pump_amt  = q_stat.nonempty ? q_stat.head.water : amt_q;
	assign pump_prod = 18'(pump_amt) * 18'(ms_per_ml_q);
	assign pump_time = (pump_prod[17:16] != 2'b00) ? 16'hFFFF : pump_prod[15:0];

	// Sensor compares, signed against unsigned thresholds
	assign level_ok = $signed({item.water_level_reading[15], item.water_level_reading})
	                  >= $signed({10'b0, min_level_q});
	assign too_dry  = $signed({item.moisture_reading[15], item.moisture_reading})
	                  < $signed({10'b0, sp_q});

	// Next state for the transaction in flight
	always_comb begin
		mode_d   = mode_q;
		sp_d     = sp_q;
		amt_d    = amt_q;
		auto_d   = auto_q;
		pub_d    = pub_q;
		pump_d   = pump_q;
		err_d    = err_q;
		status   = 1'b0;
		dropped  = 1'b0;
		pump_req = 1'b0;
		q_req.push  = 1'b0;
		q_req.pop   = 1'b0;
		q_req.entry = cmd_entry;
		if (go) begin
			unique case (item.func)
				ipc_pkg::FUNC_TICK: begin
					pump_d = (pump_q != '0) ? pump_q - 1'b1 : pump_q;
					auto_d = (auto_q != '0) ? auto_q - 1'b1 : auto_q;
					pub_d  = (pub_q != '0) ? pub_q - 1'b1 : pub_q;
				end
				ipc_pkg::FUNC_STEP: begin
					err_d[ipc_pkg::ERR_PRESSURE_BIT] = item.water_level_reading[15];
					if (q_stat.nonempty) begin
						q_req.pop = 1'b1;
						mode_d    = q_stat.head.mode;
						sp_d      = q_stat.head.moisture;
						amt_d     = q_stat.head.water;
						if (q_stat.head.mode == ipc_pkg::RUN_MANUAL) begin
							pump_req = 1'b1;
							pub_d    = after_cmd_q;
						end else begin
							auto_d = retry_q;
						end
					end else if (mode_q == ipc_pkg::RUN_AUTO) begin
						if (too_dry && auto_q == '0) begin
							pump_req = 1'b1;
							auto_d   = retry_q;
						end
					end
					// Start the pump only on a sufficient tank level
					if (pump_req) begin
						if (level_ok) begin
							if (pump_time != '0) begin
								pump_d = pump_time;
							end
							err_d[ipc_pkg::ERR_LEVEL_BIT] = 1'b0;
						end else begin
							err_d[ipc_pkg::ERR_LEVEL_BIT] = 1'b1;
						end
					end
					if (pub_d == '0) begin
						pub_d  = period_q;
						status = 1'b1;
					end
				end
				ipc_pkg::FUNC_CMD: begin
					if (q_stat.full) begin
						dropped = 1'b1;
					end else begin
						q_req.push = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Hold controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ipc_pkg::RUN_MANUAL;
			sp_q   <= '0;
			amt_q  <= '0;
			auto_q <= ipc_pkg::AUTO_RETRY_MS_RST;
			pub_q  <= ipc_pkg::PUBLISH_PERIOD_MS_RST;
			pump_q <= '0;
			err_q  <= '0;
		end else begin
			mode_q <= mode_d;
			sp_q   <= sp_d;
			amt_q  <= amt_d;
			auto_q <= auto_d;
			pub_q  <= pub_d;
			pump_q <= pump_d;
			err_q  <= err_d;
		end
	end

	// Build the result transaction
	assign result.pump_on            = (pump_d != '0);
	assign result.error_flags        = err_d;
	assign result.current_mode       = mode_d;
	assign result.status_valid       = status;
	assign result.status_water_level = status ? item.water_level_reading : '0;
	assign result.status_light       = status ? item.light_reading : '0;
	assign result.status_moisture    = status ? item.moisture_reading : '0;
	assign result.command_dropped    = dropped;

endmodule

@@ hw/rtl/irrigation_pump_controller.sv @@
// An accepted transaction is registered in stage 1 and its result in the
// stage 2 output register. Throughput: one transaction per cycle unless
// out_stall holds a result; the queue memory is read when an item is accepted
// and written back from the processing stage, with forwarding.
// Reset: asynchronous, active low; registers return to their defaults, the
// queue comes up empty and its memory is not cleared.
module irrigation_pump_controller #(
	parameter int QUEUE_DEPTH = ipc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ipc_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ipc_pkg::out_item_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ipc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ipc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic               valid_s1;
	ipc_pkg::in_item_t  item_s1;
	logic               valid_s2;
	ipc_pkg::out_item_t item_s2;
	logic               in_accept;
	logic               go_s1;
	ipc_pkg::cfg_wr_t   cfg_wr;
	ipc_pkg::q_req_t    q_req;
	ipc_pkg::q_stat_t   q_stat;
	ipc_pkg::out_item_t result;

	// Handshake: stage 1 moves whenever the output register can take a result
	assign go_s1     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !go_s1;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	// Stage 1: hold the accepted transaction while the queue head is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
		end
	end

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			item_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = item_s2;

	ipc_cmd_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_accept),
		.req    (q_req),
		.stat   (q_stat)
	);

	ipc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_wr),
		.go     (go_s1),
		.item   (item_s1),
		.q_stat (q_stat),
		.q_req  (q_req),
		.result (result)
	);

endmodule

@@ hw/rtl/ipc_checker.sv @@
module ipc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input ipc_pkg::out_item_t out_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Input backpressure only when the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// Status fields are zero without a status report
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.status_valid |->
			out_data.status_water_level == '0 && out_data.status_light == '0 &&
			out_data.status_moisture == '0)
		else $error("status fields set without status report");

	// A dropped command never carries a status report
	a_drop_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.command_dropped |-> !out_data.status_valid)
		else $error("status on a command transaction");

	// A negative reported level shows the pressure error
	a_pressure_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status_valid && out_data.status_water_level[15] |->
			out_data.error_flags[ipc_pkg::ERR_PRESSURE_BIT])
		else $error("pressure error missing for negative level");

endmodule

bind irrigation_pump_controller ipc_checker u_ipc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
